/* hw/rtl/salsa20_stream_xor_defines.svh */
// Assertion macros shared by the keystream engine modules.
`ifndef SALSA20_STREAM_XOR_DEFINES_SVH
`define SALSA20_STREAM_XOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define SS20_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define SS20_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ss20_pkg.sv */
// Shared types and constants of the Salsa20 stream XOR engine.
`timescale 1ns / 1ps
package ss20_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned WORD_COUNT  = 16;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned WADDR_W     = 4;
  localparam int unsigned CFG_REGS    = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef logic [31:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_NONCE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_STORE
  } core_state_e;

  typedef enum logic [1:0] {
    BACK_STREAM,
    BACK_GEN,
    BACK_READY
  } back_state_e;

  // One classified input byte as it waits between front and back.
  typedef struct packed {
    logic [7:0]       data;
    logic             frame_end;
    logic [POS_W-1:0] pos;
    logic             new_block;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] addr;
    word_t              data;
  } ram_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

/* hw/rtl/ss20_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ss20_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ss20_fifo.sv */
// Small flop-based queue used between front and back and for results.
`timescale 1ns / 1ps
module ss20_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr_en) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (rd_en) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/ss20_front.sv */
// Front end: tags each accepted byte with its keystream position.
`timescale 1ns / 1ps
module ss20_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            frame_end_i,
  input  logic            cfg_clr_i,
  output ss20_pkg::item_t item_o
);
  import ss20_pkg::*;

  logic             blk_valid_q, blk_valid_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] next_pos;

  // The position is held at zero whenever no block is live.
  assign item_o.data      = data_byte_i;
  assign item_o.frame_end = frame_end_i;
  assign item_o.pos       = pos_q;
  assign item_o.new_block = !blk_valid_q;

  assign next_pos = pos_q + 1'b1;

  always_comb begin
    blk_valid_d = blk_valid_q;
    pos_d       = pos_q;
    if (accept_i) begin
      if ((next_pos == '0) || frame_end_i) begin
        blk_valid_d = 1'b0;
        pos_d       = '0;
      end else begin
        blk_valid_d = 1'b1;
        pos_d       = next_pos;
      end
    end
    if (cfg_clr_i) begin
      blk_valid_d = 1'b0;
      pos_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      blk_valid_q <= blk_valid_d;
      pos_q       <= pos_d;
    end
  end

endmodule

/* hw/rtl/ss20_core.sv */
// Keystream block generator: half a Salsa20 round per cycle, then add-back.
`timescale 1ns / 1ps
`include "salsa20_stream_xor_defines.svh"
module ss20_core #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ss20_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [63:0]                      cfg_data_i,
  input  logic                             start_i,
  output ss20_pkg::core_stat_t             stat_o,
  output ss20_pkg::ram_wr_t                ram_wr_o
);
  import ss20_pkg::*;

  localparam int unsigned RND_W = $clog2(ROUND_COUNT);
  localparam logic [RND_W-1:0]   LAST_RND  = RND_W'(ROUND_COUNT - 1);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // Word indices a, b, c, d of the four quarter rounds; entry q*4+k.
  localparam logic [15:0][3:0] COL_IDX = {
    4'd11, 4'd7,  4'd3,  4'd15,
    4'd6,  4'd2,  4'd14, 4'd10,
    4'd1,  4'd13, 4'd9,  4'd5,
    4'd12, 4'd8,  4'd4,  4'd0
  };
  localparam logic [15:0][3:0] ROW_IDX = {
    4'd14, 4'd13, 4'd12, 4'd15,
    4'd9,  4'd8,  4'd11, 4'd10,
    4'd4,  4'd7,  4'd6,  4'd5,
    4'd3,  4'd2,  4'd1,  4'd0
  };

  function automatic word_t rotl32(word_t v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  core_state_e        state_q, state_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic               half_q, half_d;
  logic [WADDR_W-1:0] widx_q, widx_d;
  logic [63:0]        ctr_q, ctr_d;
  logic [63:0]        key0_q, key0_d, key1_q, key1_d, key2_q, key2_d, key3_q, key3_d;
  logic [63:0]        nonce_q, nonce_d;
  word_t              w_q [WORD_COUNT];
  word_t              w_d [WORD_COUNT];
  word_t              w_round [WORD_COUNT];
  word_t              in_w [WORD_COUNT];
  logic [3:0]         sel [4][4];
  word_t              qa [4], qb [4], qc [4], qd [4];
  word_t              na [4], nb [4], nc [4], nd [4];
  logic               done;

  assign in_w[0]  = SIGMA0;
  assign in_w[1]  = key0_q[31:0];
  assign in_w[2]  = key0_q[63:32];
  assign in_w[3]  = key1_q[31:0];
  assign in_w[4]  = key1_q[63:32];
  assign in_w[5]  = SIGMA1;
  assign in_w[6]  = nonce_q[31:0];
  assign in_w[7]  = nonce_q[63:32];
  assign in_w[8]  = ctr_q[31:0];
  assign in_w[9]  = ctr_q[63:32];
  assign in_w[10] = SIGMA2;
  assign in_w[11] = key2_q[31:0];
  assign in_w[12] = key2_q[63:32];
  assign in_w[13] = key3_q[31:0];
  assign in_w[14] = key3_q[63:32];
  assign in_w[15] = SIGMA3;

  // Even rounds work on columns, odd rounds on rows.
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      for (int k = 0; k < 4; k++) begin
        sel[q][k] = rnd_q[0] ? ROW_IDX[q*4+k] : COL_IDX[q*4+k];
      end
    end
  end

  // Each quarter round is split in two halves of two dependent steps.
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      qa[q] = w_q[sel[q][0]];
      qb[q] = w_q[sel[q][1]];
      qc[q] = w_q[sel[q][2]];
      qd[q] = w_q[sel[q][3]];
      if (!half_q) begin
        nb[q] = qb[q] ^ rotl32(qa[q] + qd[q], 7);
        nc[q] = qc[q] ^ rotl32(nb[q] + qa[q], 9);
        na[q] = qa[q];
        nd[q] = qd[q];
      end else begin
        nd[q] = qd[q] ^ rotl32(qc[q] + qb[q], 13);
        na[q] = qa[q] ^ rotl32(nd[q] + qc[q], 18);
        nb[q] = qb[q];
        nc[q] = qc[q];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WORD_COUNT; i++) begin
      w_round[i] = w_q[i];
    end
    for (int q = 0; q < 4; q++) begin
      w_round[sel[q][0]] = na[q];
      w_round[sel[q][1]] = nb[q];
      w_round[sel[q][2]] = nc[q];
      w_round[sel[q][3]] = nd[q];
    end
  end

  always_comb begin
    key0_d  = key0_q;
    key1_d  = key1_q;
    key2_d  = key2_q;
    key3_d  = key3_q;
    nonce_d = nonce_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY0:  key0_d  = cfg_data_i;
        CFG_KEY1:  key1_d  = cfg_data_i;
        CFG_KEY2:  key2_d  = cfg_data_i;
        CFG_KEY3:  key3_d  = cfg_data_i;
        CFG_NONCE: nonce_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    half_d  = half_q;
    widx_d  = widx_q;
    ctr_d   = ctr_q;
    done    = 1'b0;
    for (int i = 0; i < WORD_COUNT; i++) begin
      w_d[i] = w_q[i];
    end
    unique case (state_q)
      CORE_IDLE: begin
        if (start_i) begin
          state_d = CORE_ROUND;
          rnd_d   = '0;
          half_d  = 1'b0;
          for (int i = 0; i < WORD_COUNT; i++) begin
            w_d[i] = in_w[i];
          end
        end
      end
      CORE_ROUND: begin
        half_d = ~half_q;
        for (int i = 0; i < WORD_COUNT; i++) begin
          w_d[i] = w_round[i];
        end
        if (half_q) begin
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == LAST_RND) begin
            state_d = CORE_STORE;
            widx_d  = '0;
          end
        end
      end
      CORE_STORE: begin
        widx_d = widx_q + 1'b1;
        if (widx_q == LAST_WORD) begin
          done    = 1'b1;
          ctr_d   = ctr_q + 64'd1;
          state_d = CORE_IDLE;
        end
      end
      default: state_d = CORE_IDLE;
    endcase
    if (cfg_we_i) begin
      ctr_d = '0;
    end
  end

  assign ram_wr_o.we   = (state_q == CORE_STORE);
  assign ram_wr_o.addr = widx_q;
  assign ram_wr_o.data = w_q[widx_q] + in_w[widx_q];
  assign stat_o.busy   = (state_q != CORE_IDLE);
  assign stat_o.done   = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      rnd_q   <= '0;
      half_q  <= 1'b0;
      widx_q  <= '0;
      ctr_q   <= '0;
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      nonce_q <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      half_q  <= half_d;
      widx_q  <= widx_d;
      ctr_q   <= ctr_d;
      key0_q  <= key0_d;
      key1_q  <= key1_d;
      key2_q  <= key2_d;
      key3_q  <= key3_d;
      nonce_q <= nonce_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < WORD_COUNT; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  `SS20_ASSERT_NEXT(a_store_order, ram_wr_o.we && (ram_wr_o.addr != LAST_WORD), ram_wr_o.we && (ram_wr_o.addr == $past(ram_wr_o.addr) + 1'b1), "keystream words not stored in order")
  `SS20_ASSERT_IMPL(a_busy_from_start, $rose(stat_o.busy), $past(start_i), "core went busy without a start")
  `SS20_ASSERT_NEXT(a_idle_after_done, stat_o.done, !stat_o.busy, "core still busy after finishing a block")

endmodule

/* hw/rtl/ss20_back.sv */
// Back end: orders block generation, reads keystream and forms results.
`timescale 1ns / 1ps
`include "salsa20_stream_xor_defines.svh"
module ss20_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            head_valid_i,
  input  ss20_pkg::item_t                 head_i,
  output logic                            head_pop_o,
  output logic                            core_start_o,
  input  ss20_pkg::core_stat_t            core_stat_i,
  output logic                            ram_re_o,
  output logic [ss20_pkg::WADDR_W-1:0]    ram_raddr_o,
  input  ss20_pkg::word_t                 ram_rdata_i,
  input  logic [ss20_pkg::OUT_CNT_W-1:0]  out_count_i,
  output logic                            out_push_o,
  output ss20_pkg::result_t               out_item_o
);
  import ss20_pkg::*;

  back_state_e          state_q, state_d;
  logic                 s1_valid_q;
  logic [7:0]           s1_data_q;
  logic                 s1_fe_q;
  logic [1:0]           s1_sel_q;
  logic [OUT_CNT_W:0]   fill;
  logic                 room;
  logic [7:0]           key_byte;

  // Count the byte in the read stage so the result queue cannot overflow.
  assign fill = (OUT_CNT_W + 1)'(out_count_i) + (OUT_CNT_W + 1)'(s1_valid_q);
  assign room = (fill < (OUT_CNT_W + 1)'(OUT_DEPTH));

  always_comb begin
    state_d      = state_q;
    head_pop_o   = 1'b0;
    core_start_o = 1'b0;
    unique case (state_q)
      BACK_STREAM: begin
        if (head_valid_i) begin
          if (head_i.new_block) begin
            core_start_o = 1'b1;
            state_d      = BACK_GEN;
          end else if (room) begin
            head_pop_o = 1'b1;
          end
        end
      end
      BACK_GEN: begin
        if (core_stat_i.done) begin
          state_d = BACK_READY;
        end
      end
      BACK_READY: begin
        if (head_valid_i && room) begin
          head_pop_o = 1'b1;
          state_d    = BACK_STREAM;
        end
      end
      default: state_d = BACK_STREAM;
    endcase
  end

  assign ram_re_o    = head_pop_o;
  assign ram_raddr_o = head_i.pos[POS_W-1:2];

  assign key_byte             = ram_rdata_i[{s1_sel_q, 3'b000} +: 8];
  assign out_push_o           = s1_valid_q;
  assign out_item_o.data      = s1_data_q ^ key_byte;
  assign out_item_o.frame_end = s1_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BACK_STREAM;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= head_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      s1_data_q <= head_i.data;
      s1_fe_q   <= head_i.frame_end;
      s1_sel_q  <= head_i.pos[1:0];
    end
  end

  `SS20_ASSERT_IMPL(a_out_room, out_push_o, out_count_i != OUT_CNT_W'(OUT_DEPTH), "result pushed into a full queue")
  `SS20_ASSERT_IMPL(a_fresh_block, head_pop_o && head_i.new_block, state_q == BACK_READY, "byte left before its keystream block was made")
  `SS20_ASSERT_IMPL(a_start_idle, core_start_o, !core_stat_i.busy, "block started while the core was busy")

endmodule

/* hw/rtl/salsa20_stream_xor.sv */
// A byte in a live keystream block passes the mid queue, RAM read stage and result queue.
// A byte that opens a block (after reset, a key or nonce write, a frame end or 64 bytes) waits
// for all ROUND_COUNT rounds, the 16-word add-back and the handover. Throughput: one byte per
// cycle in a block while the result queue has room, set by the single keystream RAM read port.
// Reset clears control state, the block counter and the key and nonce registers to zero;
// the keystream RAM is not cleared and is always written before it is read.
`timescale 1ns / 1ps
module salsa20_stream_xor #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      data_byte_i,
  input  logic                            frame_end_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      cipher_byte_o,
  output logic                            frame_end_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ss20_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);
  import ss20_pkg::*;

  logic                 accept;
  logic                 cfg_hit;
  item_t                front_item;
  item_t                mid_head;
  logic                 mid_empty;
  logic                 mid_pop;
  logic                 core_start;
  core_stat_t           core_stat;
  ram_wr_t              ram_wr;
  logic                 ram_re;
  logic [WADDR_W-1:0]   ram_raddr;
  word_t                ram_rdata;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_push;
  result_t              out_item;
  result_t              out_head;

  assign cfg_ready_o = 1'b1;
  // Writes to indexes beyond the register list leave everything untouched.
  assign cfg_hit = cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(CFG_REGS));
  assign accept  = push && !full;

  ss20_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .cfg_clr_i   (cfg_hit),
    .item_o      (front_item)
  );

  ss20_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .pop_i   (mid_pop),
    .rdata_o (mid_head),
    .full_o  (full),
    .empty_o (mid_empty),
    .count_o ()
  );

  ss20_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_hit),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (core_start),
    .stat_o      (core_stat),
    .ram_wr_o    (ram_wr)
  );

  ss20_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (WORD_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ss20_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!mid_empty),
    .head_i       (mid_head),
    .head_pop_o   (mid_pop),
    .core_start_o (core_start),
    .core_stat_i  (core_stat),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_count_i  (out_count),
    .out_push_o   (out_push),
    .out_item_o   (out_item)
  );

  ss20_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_item),
    .pop_i   (pop),
    .rdata_o (out_head),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign cipher_byte_o   = out_head.data;
  assign frame_end_out_o = out_head.frame_end;

endmodule
